// ===== rtl/core/sgmv_pkg.sv =====
// ----------------------------------------------------------------------------
// sgmv_pkg
// Shared types, sizes and codes of the sparse GF(2) matrix-vector multiplier.
// ----------------------------------------------------------------------------
package sgmv_pkg;

  localparam int VEC_DEPTH = 4096;
  localparam int WORD_BITS = 64;
  localparam int ADDR_W    = $clog2(VEC_DEPTH);
  localparam int CFG_W     = 13;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_START  = 2'd1,
    MODE_MATRIX = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_TRANSPOSED  = 2'd0,
    REG_STORED_ROWS = 2'd1,
    REG_DEST_LEN    = 2'd2,
    REG_SOURCE_LEN  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MEMWAIT
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] index;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        done_res;
    logic        index_error;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the accepted transaction
    logic exec;      // decode and walk update
    logic mem;       // registered memory data is valid, finish the RMW
    logic clear_en;  // destination clearing sweep
    logic finish;    // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic go_mem;
    logic clear_last;
  } status_t;

endpackage

// ===== rtl/core/sparse_gf2_matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// sparse_gf2_matrix_vector_multiply
// Path, start to strobe: loads, length words, bad entries and other items with
// no memory access go through EXEC; reads and applied entries add MEMWAIT
// (registered read, then XOR write); start adds the one-word-a-cycle destination sweep.
// Transactions are taken one at a time; busy stays high until each finishes.
// Reset: synchronous; a sweep then clears all VEC_DEPTH words with busy high.
// Results cannot be stalled: each strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module sparse_gf2_matrix_vector_multiply import sgmv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         item,
  output out_item_t        result,
  output logic             strobe,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  sgmv_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sgmv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result),
    .strobe    (strobe)
  );

endmodule

// ===== rtl/core/sgmv_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgmv_ctrl
// Sequencer: clearing sweep, transaction accept, execute and memory phases.
// ----------------------------------------------------------------------------
module sgmv_ctrl import sgmv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state, state_next;
  logic   clear_reply, clear_reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clear_reply <= 1'b0;
    end else begin
      state       <= state_next;
      clear_reply <= clear_reply_next;
    end
  end

  always_comb begin
    state_next       = state;
    clear_reply_next = clear_reply;
    cmd              = '0;
    busy             = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_next       = ST_IDLE;
          cmd.finish       = clear_reply;
          clear_reply_next = 1'b0;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.is_start) begin
          state_next       = ST_CLEAR;
          clear_reply_next = 1'b1;
        end else if (status.go_mem) begin
          state_next = ST_MEMWAIT;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MEMWAIT: begin
        cmd.mem    = 1'b1;
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/core/sgmv_datapath.sv =====
// ----------------------------------------------------------------------------
// sgmv_datapath
// Vector stores, matrix walk state, bounds checks and the XOR update.
// ----------------------------------------------------------------------------
module sgmv_datapath import sgmv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  in_item_t         item,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_data,
  output status_t          status,
  output out_item_t        result,
  output logic             strobe
);

  // configuration
  logic             transposed;
  logic [CFG_W-1:0] stored_rows;
  logic [CFG_W-1:0] dest_length;
  logic [CFG_W-1:0] source_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      transposed    <= 1'b0;
      stored_rows   <= '0;
      dest_length   <= '0;
      source_length <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_addr))
        REG_TRANSPOSED:  transposed    <= cfg_data[0];
        REG_STORED_ROWS: stored_rows   <= cfg_data;
        REG_DEST_LEN:    dest_length   <= cfg_data;
        REG_SOURCE_LEN:  source_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured transaction
  in_item_t item_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) item_q <= item;
  end

  // walk state
  logic [CFG_W-1:0] row_counter, row_counter_next;
  logic [31:0]      entries_left, entries_left_next;
  logic [31:0]      col_acc, col_acc_next;
  logic             expect_length, expect_length_next;

  logic [31:0]      word, col_sum, row32, idx32, col_lim;
  logic             walking, entry_err, do_apply, do_read;
  logic [ADDR_W-1:0] src_rd_addr, dst_rd_addr;

  assign word    = item_q.value[31:0];
  assign col_sum = col_acc + word;
  assign row32   = 32'(row_counter);
  assign idx32   = 32'(item_q.index);
  assign walking = (item_q.mode == MODE_MATRIX) && (row_counter < stored_rows);
  assign col_lim = transposed ? 32'(dest_length) : 32'(source_length);

  always_comb begin
    row_counter_next   = row_counter;
    entries_left_next  = entries_left;
    col_acc_next       = col_acc;
    expect_length_next = expect_length;
    entry_err          = 1'b0;
    do_apply           = 1'b0;
    if (cmd.exec && item_q.mode == MODE_START) begin
      row_counter_next   = '0;
      entries_left_next  = '0;
      col_acc_next       = '0;
      expect_length_next = 1'b1;
    end else if (cmd.exec && walking) begin
      if (expect_length) begin
        entries_left_next = word;
        col_acc_next      = '0;
        if (word == '0) begin
          row_counter_next = row_counter + CFG_W'(1);
        end else begin
          expect_length_next = 1'b0;
        end
      end else begin
        col_acc_next = col_sum;
        // row beyond the store, or column beyond the active length or store
        entry_err = (row32 >= 32'(VEC_DEPTH)) || (col_sum >= col_lim)
                 || (col_sum >= 32'(VEC_DEPTH));
        do_apply  = !entry_err;
        entries_left_next = entries_left - 32'(1);
        if (entries_left_next == '0) begin
          row_counter_next   = row_counter + CFG_W'(1);
          expect_length_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter   <= '0;
      entries_left  <= '0;
      col_acc       <= '0;
      expect_length <= 1'b1;
    end else begin
      row_counter   <= row_counter_next;
      entries_left  <= entries_left_next;
      col_acc       <= col_acc_next;
      expect_length <= expect_length_next;
    end
  end

  assign do_read = (item_q.mode == MODE_READ) && (idx32 < 32'(VEC_DEPTH));

  always_comb begin
    if (item_q.mode == MODE_READ) begin
      src_rd_addr = idx32[ADDR_W-1:0];
      dst_rd_addr = idx32[ADDR_W-1:0];
    end else if (transposed) begin
      src_rd_addr = row32[ADDR_W-1:0];
      dst_rd_addr = col_sum[ADDR_W-1:0];
    end else begin
      src_rd_addr = col_sum[ADDR_W-1:0];
      dst_rd_addr = row32[ADDR_W-1:0];
    end
  end

  // clearing sweep counter
  logic [ADDR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= status.clear_last ? '0 : clr_cnt + ADDR_W'(1);
    end
  end

  assign status.clear_last = (clr_cnt == ADDR_W'(VEC_DEPTH - 1));
  assign status.is_start   = (item_q.mode == MODE_START);
  assign status.go_mem     = do_apply || do_read;

  // source store
  logic [WORD_BITS-1:0] src_mem [VEC_DEPTH];
  logic [WORD_BITS-1:0] src_q;

  always_ff @(posedge clk) begin
    if (cmd.exec && item_q.mode == MODE_LOAD && idx32 < 32'(VEC_DEPTH)) begin
      src_mem[idx32[ADDR_W-1:0]] <= item_q.value[WORD_BITS-1:0];
    end
    src_q <= src_mem[src_rd_addr];
  end

  // destination store: one write port shared by the sweep and the RMW
  logic [WORD_BITS-1:0] dst_mem [VEC_DEPTH];
  logic [WORD_BITS-1:0] dst_q;
  logic [ADDR_W-1:0]    dst_addr_q;
  logic                 dst_we;
  logic [ADDR_W-1:0]    dst_wr_addr;
  logic [WORD_BITS-1:0] dst_wr_data;

  always_ff @(posedge clk) begin
    if (cmd.exec) dst_addr_q <= dst_rd_addr;
  end

  always_comb begin
    dst_we      = cmd.clear_en || (cmd.mem && item_q.mode == MODE_MATRIX);
    dst_wr_addr = cmd.clear_en ? clr_cnt : dst_addr_q;
    dst_wr_data = cmd.clear_en ? '0 : (dst_q ^ src_q);
  end

  always_ff @(posedge clk) begin
    if (dst_we) dst_mem[dst_wr_addr] <= dst_wr_data;
    dst_q <= dst_mem[dst_rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.read_data   <= (cmd.mem && item_q.mode == MODE_READ) ? 64'(dst_q) : '0;
      result.done_res    <= (row_counter_next >= stored_rows);
      result.index_error <= cmd.exec && entry_err;
    end
  end

endmodule

// ===== rtl/core/sgmv_checker.sv =====
// ----------------------------------------------------------------------------
// sgmv_checker
// Port-level checks on transaction timing and result contents.
// ----------------------------------------------------------------------------
module sgmv_checker import sgmv_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input in_item_t  item,
  input out_item_t result,
  input logic      strobe
);

  // an accepted transaction holds the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after accepted transaction");

  // result strobes never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("back-to-back result strobes");

  // after accept, a source load goes through EXEC and then raises strobe
  a_load_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.mode == MODE_LOAD |=> ##1 strobe)
    else $error("load result missing");

  // an index error never carries read data
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    strobe && result.index_error |-> result.read_data == '0)
    else $error("index error with read data");

endmodule

bind sparse_gf2_matrix_vector_multiply sgmv_checker u_sgmv_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .result (result),
  .strobe (strobe)
);
